@@ hdl/rgbv_pkg.sv @@
// Shared types and constants of the RGB to YCbCr 4:2:2 v210 packer.
package rgbv_pkg;

  localparam int COMP_W     = 10;
  localparam int WORD_W     = 30;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 21;
  localparam int CFG_REG_W  = 63;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Sums only need to be exact modulo 2^30, bits 29..20 are the component.
  localparam logic [WORD_W-1:0] LUMA_OFFSET   = 30'h0400_0000;  // 64 << 20
  localparam logic [WORD_W-1:0] CHROMA_OFFSET = 30'h2008_0000;  // 1025 << 19

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA     = 8'd0,
    REG_CHROMA_A = 8'd1,
    REG_CHROMA_B = 8'd2
  } reg_idx_t;

  // One converted pixel on its way from the front to the packer.
  typedef struct packed {
    logic [COMP_W-1:0] chroma_a;
    logic [COMP_W-1:0] luma;
    logic [COMP_W-1:0] chroma_b;
    logic              odd;
    logic              eol;
  } entry_t;

endpackage

@@ hdl/rgbv_pixel_if.sv @@
// Pixel input channel: valid/ready with one RGB pixel per word.
interface rgbv_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [rgbv_pkg::SAMPLE_W-1:0] red;
  logic [rgbv_pkg::SAMPLE_W-1:0] green;
  logic [rgbv_pkg::SAMPLE_W-1:0] blue;
  logic                          end_of_line;

  modport source (output valid, red, green, blue, end_of_line, input ready);
  modport sink   (input valid, red, green, blue, end_of_line, output ready);
endinterface

@@ hdl/rgbv_word_if.sv @@
// Packed output channel: valid/ready with one v210 word per handshake.
interface rgbv_word_if;
  logic                        valid;
  logic                        ready;
  logic [rgbv_pkg::WORD_W-1:0] packed_word;
  logic                        line_done;

  modport source (output valid, packed_word, line_done, input ready);
  modport sink   (input valid, packed_word, line_done, output ready);
endinterface

@@ hdl/rgbv_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
interface rgbv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rgbv_pkg::CFG_IDX_W-1:0]  index;
  logic [rgbv_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rgbv_front.sv @@
// Front end: coefficient registers, pixel accept, matrix multiply and sum.
module rgbv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbv_pixel_if.sink           in_pix,
  rgbv_cfg_if.sink             cfg_wr,
  output logic                 push_valid,
  output rgbv_pkg::entry_t     push_data,
  input  logic                 push_ready
);

  function automatic logic [rgbv_pkg::WORD_W-1:0] wmul(
    input logic signed [rgbv_pkg::COEF_W-1:0] w,
    input logic        [rgbv_pkg::COMP_W-1:0] s
  );
    logic signed [31:0] p;
    p = w * $signed({1'b0, s});
    return p[rgbv_pkg::WORD_W-1:0];
  endfunction

  logic [rgbv_pkg::CFG_REG_W-1:0] luma_r, cha_r, chb_r;
  logic [rgbv_pkg::CFG_REG_W-1:0] luma_nxt, cha_nxt, chb_nxt;
  logic odd_r, odd_nxt;
  logic s1_v_r, s1_v_nxt;
  logic s1_odd_r, s1_eol_r;
  // [component][color]: component 0 chroma A, 1 luma, 2 chroma B
  logic [rgbv_pkg::WORD_W-1:0] prod_r   [3][3];
  logic [rgbv_pkg::WORD_W-1:0] prod_nxt [3][3];
  logic [rgbv_pkg::COMP_W-1:0] r10, g10, b10;
  logic [rgbv_pkg::WORD_W-1:0] sum_a, sum_y, sum_b;
  logic accept, advance;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    luma_nxt = luma_r;
    cha_nxt  = cha_r;
    chb_nxt  = chb_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        rgbv_pkg::REG_LUMA:     luma_nxt = cfg_wr.data[rgbv_pkg::CFG_REG_W-1:0];
        rgbv_pkg::REG_CHROMA_A: cha_nxt  = cfg_wr.data[rgbv_pkg::CFG_REG_W-1:0];
        rgbv_pkg::REG_CHROMA_B: chb_nxt  = cfg_wr.data[rgbv_pkg::CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance      = push_ready || !s1_v_r;
  assign in_pix.ready = advance;
  assign accept       = in_pix.valid && advance;

  assign r10 = in_pix.red[rgbv_pkg::SAMPLE_W-1:rgbv_pkg::SAMPLE_W-rgbv_pkg::COMP_W];
  assign g10 = in_pix.green[rgbv_pkg::SAMPLE_W-1:rgbv_pkg::SAMPLE_W-rgbv_pkg::COMP_W];
  assign b10 = in_pix.blue[rgbv_pkg::SAMPLE_W-1:rgbv_pkg::SAMPLE_W-rgbv_pkg::COMP_W];

  always_comb begin
    prod_nxt[0][0] = wmul(cha_r[20:0],  r10);
    prod_nxt[0][1] = wmul(cha_r[41:21], g10);
    prod_nxt[0][2] = wmul(cha_r[62:42], b10);
    prod_nxt[1][0] = wmul(luma_r[20:0],  r10);
    prod_nxt[1][1] = wmul(luma_r[41:21], g10);
    prod_nxt[1][2] = wmul(luma_r[62:42], b10);
    prod_nxt[2][0] = wmul(chb_r[20:0],  r10);
    prod_nxt[2][1] = wmul(chb_r[41:21], g10);
    prod_nxt[2][2] = wmul(chb_r[62:42], b10);
  end

  // parity of the next pixel; end of line restarts on an even pixel
  always_comb begin
    odd_nxt  = odd_r;
    s1_v_nxt = s1_v_r;
    if (advance) s1_v_nxt = accept;
    if (accept) odd_nxt = in_pix.end_of_line ? 1'b0 : !odd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_r <= '0;
      cha_r  <= '0;
      chb_r  <= '0;
      odd_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      luma_r <= luma_nxt;
      cha_r  <= cha_nxt;
      chb_r  <= chb_nxt;
      odd_r  <= odd_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r   <= prod_nxt;
      s1_odd_r <= odd_r;
      s1_eol_r <= in_pix.end_of_line;
    end
  end

  assign sum_a = rgbv_pkg::CHROMA_OFFSET + prod_r[0][0] + prod_r[0][1] + prod_r[0][2];
  assign sum_y = rgbv_pkg::LUMA_OFFSET   + prod_r[1][0] + prod_r[1][1] + prod_r[1][2];
  assign sum_b = rgbv_pkg::CHROMA_OFFSET + prod_r[2][0] + prod_r[2][1] + prod_r[2][2];

  assign push_valid         = s1_v_r;
  assign push_data.chroma_a = sum_a[29:20];
  assign push_data.luma     = sum_y[29:20];
  assign push_data.chroma_b = sum_b[29:20];
  assign push_data.odd      = s1_odd_r;
  assign push_data.eol      = s1_eol_r;

endmodule

@@ hdl/rgbv_queue.sv @@
// Small FIFO of converted pixels between the front end and the packer.
module rgbv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  rgbv_pkg::entry_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output rgbv_pkg::entry_t pop_data,
  input  logic             pop_ready
);

  rgbv_pkg::entry_t mem_r [rgbv_pkg::QUEUE_DEPTH];
  logic [rgbv_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rgbv_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = count_r != (rgbv_pkg::QUEUE_AW+1)'(rgbv_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ hdl/rgbv_back.sv @@
// Back end: slots components into v210 words and drives the output register.
module rgbv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  rgbv_pkg::entry_t pop_data,
  output logic             pop_ready,
  rgbv_word_if.source      out_word
);

  logic [1:0]                  slot_r, slot_nxt;
  logic [rgbv_pkg::WORD_W-1:0] part_r, part_nxt;
  logic                        sec_v_r, sec_v_nxt;
  logic [rgbv_pkg::WORD_W-1:0] sec_word_r, sec_word_nxt;
  logic                        out_v_r, out_v_nxt;
  logic [rgbv_pkg::WORD_W-1:0] out_word_r, out_word_nxt;
  logic                        out_done_r, out_done_nxt;

  logic                        load_ok, pop;
  logic                        complete, flush;
  logic [rgbv_pkg::WORD_W-1:0] cw, np;
  logic [1:0]                  ns;
  logic [rgbv_pkg::COMP_W-1:0] ca, cy, cb;

  assign ca = pop_data.chroma_a;
  assign cy = pop_data.luma;
  assign cb = pop_data.chroma_b;

  assign load_ok   = !out_v_r || out_word.ready;
  assign pop       = pop_valid && !sec_v_r && load_ok;
  assign pop_ready = !sec_v_r && load_ok;

  // slot the pixel's components; partial word bits above the slot are zero
  always_comb begin
    complete = 1'b0;
    cw       = '0;
    np       = part_r;
    ns       = slot_r;
    if (!pop_data.odd) begin
      complete = 1'b1;
      case (slot_r)
        2'd1: begin
          cw = part_r | {cy, ca, 10'd0};
          np = {20'd0, cb};
          ns = 2'd1;
        end
        2'd2: begin
          cw = part_r | {ca, 20'd0};
          np = {10'd0, cb, cy};
          ns = 2'd2;
        end
        default: begin
          cw = {cb, cy, ca};
          np = '0;
          ns = 2'd0;
        end
      endcase
    end else begin
      case (slot_r)
        2'd1: begin
          np = part_r | {10'd0, cy, 10'd0};
          ns = 2'd2;
        end
        2'd2: begin
          complete = 1'b1;
          cw = part_r | {cy, 20'd0};
          np = '0;
          ns = 2'd0;
        end
        default: begin
          np = {20'd0, cy};
          ns = 2'd1;
        end
      endcase
    end
    flush = pop_data.eol && (ns != 2'd0);
  end

  always_comb begin
    slot_nxt     = slot_r;
    part_nxt     = part_r;
    sec_v_nxt    = sec_v_r;
    sec_word_nxt = sec_word_r;
    out_v_nxt    = out_v_r && !out_word.ready;
    out_word_nxt = out_word_r;
    out_done_nxt = out_done_r;
    if (sec_v_r && load_ok) begin
      // flushed partial word behind a completed one
      out_v_nxt    = 1'b1;
      out_word_nxt = sec_word_r;
      out_done_nxt = 1'b1;
      sec_v_nxt    = 1'b0;
    end else if (pop) begin
      slot_nxt = pop_data.eol ? 2'd0 : ns;
      part_nxt = pop_data.eol ? '0 : np;
      if (complete || flush) begin
        out_v_nxt    = 1'b1;
        out_word_nxt = complete ? cw : np;
        out_done_nxt = complete ? (pop_data.eol && !flush) : 1'b1;
      end
      sec_v_nxt    = complete && flush;
      sec_word_nxt = np;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 2'd0;
      part_r  <= '0;
      sec_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      part_r  <= part_nxt;
      sec_v_r <= sec_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_word_r <= sec_word_nxt;
    out_word_r <= out_word_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_word.valid       = out_v_r;
  assign out_word.packed_word = out_word_r;
  assign out_word.line_done   = out_done_r;

endmodule

@@ hdl/rgb_to_ycbcr_v210_packer.sv @@
// Top level of the RGB to YCbCr 4:2:2 converter with v210 word packing.
// Each pixel is registered as products, queued, then packed into the output
// register. Throughput: one pixel per cycle unless stalled; the single output
// register passes one word per cycle while the sink is ready. An end-of-line
// pixel yielding two words holds the packer; the four-entry queue takes it up.
// Reset (rst_n low, synchronous): coefficients, parity, slot and queue clear.
module rgb_to_ycbcr_v210_packer (
  input  logic        clk,
  input  logic        rst_n,
  rgbv_pixel_if.sink  in_pix,
  rgbv_word_if.source out_word,
  rgbv_cfg_if.sink    cfg_wr
);

  // Front end: coefficient registers, pixel parity, one stage of nine
  // 21x10 products, then the three sums with offsets feed the queue.
  // Back end: takes one converted pixel per cycle when not stalled, packs
  // components three to a word (chroma A, luma, chroma B on even pixels, luma
  // on odd ones) and flushes the partial word at end of line.

  logic             push_valid, push_ready;
  rgbv_pkg::entry_t push_data;
  logic             pop_valid, pop_ready;
  rgbv_pkg::entry_t pop_data;

  rgbv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_wr     (cfg_wr),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rgbv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  rgbv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_word  (out_word)
  );

endmodule

@@ sim/rgb_to_ycbcr_v210_packer_tb.sv @@
// Testbench for the RGB to YCbCr 4:2:2 v210 packer: random and directed pixels, scoreboarded.
`timescale 1ns / 100ps

module rgb_to_ycbcr_v210_packer_tb;

  // One pixel word as offered on the input channel.
  typedef struct packed {
    logic [rgbv_pkg::SAMPLE_W-1:0] red;
    logic [rgbv_pkg::SAMPLE_W-1:0] green;
    logic [rgbv_pkg::SAMPLE_W-1:0] blue;
    logic                          end_of_line;
  } pixel_t;

  // One packed word as expected on the output channel.
  typedef struct packed {
    logic [rgbv_pkg::WORD_W-1:0] packed_word;
    logic                        line_done;
  } v210_word_t;

  localparam int MAX_GAP     = 17;
  localparam int DRAIN_WAIT  = 8;    // margin for a pixel still in flight
  localparam int HOLD_CYCLES = 300;  // long output back-pressure stretch

  logic clk = 1'b0;
  logic rst_n;

  rgbv_pixel_if pix_if();
  rgbv_word_if  word_if();
  rgbv_cfg_if   cfg_if();

  rgb_to_ycbcr_v210_packer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if),
    .out_word (word_if),
    .cfg_wr   (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixels waiting to be offered, and words the block still owes us.
  pixel_t     pixel_backlog[$];
  v210_word_t expected_words[$];

  // Shadow of the coefficient registers (bit 63 of a write is dropped).
  logic [rgbv_pkg::CFG_REG_W-1:0] luma_coeffs;
  logic [rgbv_pkg::CFG_REG_W-1:0] chroma_a_coeffs;
  logic [rgbv_pkg::CFG_REG_W-1:0] chroma_b_coeffs;

  // Shadow of the packer state.
  int unsigned                 slot_fill;
  logic [rgbv_pkg::WORD_W-1:0] word_accum;
  logic                        odd_pixel;

  // Idle behavior, set per phase by the stimulus and hold processes at the falling edge.
  int  src_max_gap;
  int  sink_max_gap;
  bit  hold_request;
  bit  sink_hold;
  int  mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Sign-extend the three 21-bit weights and form offset + sum, modulo 2^32.
  // The component is bits 29..20 of the sum; no clamping.
  function automatic logic [rgbv_pkg::COMP_W-1:0] weighted_component(
    input logic [rgbv_pkg::CFG_REG_W-1:0] coeffs,
    input logic [31:0]                    offset,
    input logic [rgbv_pkg::COMP_W-1:0]    r,
    input logic [rgbv_pkg::COMP_W-1:0]    g,
    input logic [rgbv_pkg::COMP_W-1:0]    b
  );
    logic [31:0] wr, wg, wb, acc;
    wr  = {{11{coeffs[20]}}, coeffs[20:0]};
    wg  = {{11{coeffs[41]}}, coeffs[41:21]};
    wb  = {{11{coeffs[62]}}, coeffs[62:42]};
    acc = offset + wr * {22'd0, r} + wg * {22'd0, g} + wb * {22'd0, b};
    return acc[29:20];
  endfunction

  // Work out the words one accepted pixel produces and queue them.
  task automatic predict_pixel_words(input pixel_t px);
    logic [rgbv_pkg::COMP_W-1:0] r, g, b;
    logic [rgbv_pkg::COMP_W-1:0] comps[3];
    int                          n_comp;
    v210_word_t                  done_words[$];
    r = px.red[rgbv_pkg::SAMPLE_W-1 -: rgbv_pkg::COMP_W];
    g = px.green[rgbv_pkg::SAMPLE_W-1 -: rgbv_pkg::COMP_W];
    b = px.blue[rgbv_pkg::SAMPLE_W-1 -: rgbv_pkg::COMP_W];
    if (!odd_pixel) begin
      comps[0] = weighted_component(chroma_a_coeffs, 32'(rgbv_pkg::CHROMA_OFFSET), r, g, b);
      comps[1] = weighted_component(luma_coeffs, 32'(rgbv_pkg::LUMA_OFFSET), r, g, b);
      comps[2] = weighted_component(chroma_b_coeffs, 32'(rgbv_pkg::CHROMA_OFFSET), r, g, b);
      n_comp = 3;
    end else begin
      comps[0] = weighted_component(luma_coeffs, 32'(rgbv_pkg::LUMA_OFFSET), r, g, b);
      n_comp = 1;
    end
    for (int i = 0; i < n_comp; i++) begin
      word_accum = word_accum |
                   (rgbv_pkg::WORD_W'(comps[i]) << (rgbv_pkg::COMP_W * slot_fill));
      slot_fill++;
      if (slot_fill == 3) begin
        done_words.push_back('{packed_word: word_accum, line_done: 1'b0});
        word_accum = '0;
        slot_fill  = 0;
      end
    end
    odd_pixel = ~odd_pixel;
    if (px.end_of_line) begin
      // mid-word: flush the partial word; on a boundary: tag the last full one
      if (slot_fill != 0)
        done_words.push_back('{packed_word: word_accum, line_done: 1'b1});
      else if (done_words.size() > 0)
        done_words[done_words.size()-1].line_done = 1'b1;
      slot_fill  = 0;
      word_accum = '0;
      odd_pixel  = 1'b0;
    end
    foreach (done_words[i])
      expected_words.push_back(done_words[i]);
  endtask

  // Driver: offers the backlog one pixel at a time, with a random gap drawn
  // per pixel. Prediction happens at the edge the pixel is taken.
  int     src_wait;
  bit     src_armed;
  pixel_t next_pixel;

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      src_wait  = 0;
      src_armed = 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready)
        predict_pixel_words({pix_if.red, pix_if.green, pix_if.blue, pix_if.end_of_line});
      if (pix_if.valid && !pix_if.ready) begin
        // stalled: hold the word as is
      end else if (pixel_backlog.size() == 0) begin
        pix_if.valid <= 1'b0;
      end else begin
        if (!src_armed) begin
          src_wait  = $urandom_range(0, src_max_gap);
          src_armed = 1'b1;
        end
        if (src_wait > 0) begin
          src_wait--;
          pix_if.valid <= 1'b0;
        end else begin
          next_pixel = pixel_backlog.pop_front();
          pix_if.red         <= next_pixel.red;
          pix_if.green       <= next_pixel.green;
          pix_if.blue        <= next_pixel.blue;
          pix_if.end_of_line <= next_pixel.end_of_line;
          pix_if.valid       <= 1'b1;
          src_armed = 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word against the oldest expectation and
  // throttles ready with a stall drawn per word, or the long hold.
  int         sink_wait;
  v210_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      word_if.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (word_if.valid && word_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", word_if.packed_word));
        end else begin
          want = expected_words.pop_front();
          if (word_if.packed_word !== want.packed_word)
            report_mismatch($sformatf("packed_word %h, expected %h",
                                      word_if.packed_word, want.packed_word));
          if (word_if.line_done !== want.line_done)
            report_mismatch($sformatf("line_done %b, expected %b on word %h",
                                      word_if.line_done, want.line_done, want.packed_word));
        end
        sink_wait = $urandom_range(0, sink_max_gap);
      end
      if (sink_hold) begin
        word_if.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // Long output hold, timed in its own process; the sender keeps going meanwhile
  // so the internal queue fills and the input stalls.
  initial begin
    sink_hold = 1'b0;
    wait (hold_request);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_hold = 1'b0;
  end

  // Pack three signed weights (red, green, blue) into one register value.
  function automatic logic [rgbv_pkg::CFG_DATA_W-1:0] coeff_word(input int wr, input int wg,
                                                                 input int wb,
                                                                 input bit top_bit);
    logic [rgbv_pkg::COEF_W-1:0] r21, g21, b21;
    r21 = wr[rgbv_pkg::COEF_W-1:0];
    g21 = wg[rgbv_pkg::COEF_W-1:0];
    b21 = wb[rgbv_pkg::COEF_W-1:0];
    return {top_bit, b21, g21, r21};
  endfunction

  task automatic write_coeffs(input rgbv_pkg::reg_idx_t idx,
                              input logic [rgbv_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      rgbv_pkg::REG_LUMA:     luma_coeffs     = value[rgbv_pkg::CFG_REG_W-1:0];
      rgbv_pkg::REG_CHROMA_A: chroma_a_coeffs = value[rgbv_pkg::CFG_REG_W-1:0];
      rgbv_pkg::REG_CHROMA_B: chroma_b_coeffs = value[rgbv_pkg::CFG_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(input logic [rgbv_pkg::CFG_DATA_W-1:0] y,
                             input logic [rgbv_pkg::CFG_DATA_W-1:0] ca,
                             input logic [rgbv_pkg::CFG_DATA_W-1:0] cb);
    write_coeffs(rgbv_pkg::REG_LUMA, y);
    write_coeffs(rgbv_pkg::REG_CHROMA_A, ca);
    write_coeffs(rgbv_pkg::REG_CHROMA_B, cb);
    @(negedge clk);
  endtask

  // Block is quiet: nothing queued, nothing owed, and a DRAIN_WAIT margin for
  // any pixel that is still in flight without producing a word.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || pix_if.valid || expected_words.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [rgbv_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {rgbv_pkg::COMP_W'($urandom), 6'h00};
      3:       return {rgbv_pkg::COMP_W'($urandom), 6'h3F};
      default: return rgbv_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic pixel_t make_pixel(input logic [rgbv_pkg::SAMPLE_W-1:0] r,
                                        input logic [rgbv_pkg::SAMPLE_W-1:0] g,
                                        input logic [rgbv_pkg::SAMPLE_W-1:0] b,
                                        input bit eol);
    return '{red: r, green: g, blue: b, end_of_line: eol};
  endfunction

  // Queue whole lines of random pixels; now and then a stray end_of_line
  // breaks a line early.
  task automatic queue_lines(input int n_pixels, input int max_len);
    int queued, len;
    bit eol;
    queued = 0;
    while (queued < n_pixels) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 8);
      if (queued + len > n_pixels)
        len = n_pixels - queued;
      for (int i = 0; i < len; i++) begin
        eol = (i == len - 1) || ($urandom_range(0, 39) == 0);
        pixel_backlog.push_back(make_pixel(rand_sample(), rand_sample(), rand_sample(), eol));
      end
      queued += len;
    end
  endtask

  // BT.709 weights scaled to studio range, in units of 2^-20.
  localparam int Y_R  = 190900,  Y_G  = 642200,  Y_B  = 64830;
  localparam int CB_R = -105250, CB_G = -353950, CB_B = 459200;
  localparam int CR_R = 459200,  CR_G = -417130, CR_B = -42060;

  initial begin
    rst_n              = 1'b0;
    pix_if.valid       = 1'b0;
    pix_if.red         = '0;
    pix_if.green       = '0;
    pix_if.blue        = '0;
    pix_if.end_of_line = 1'b0;
    word_if.ready      = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = rgbv_pkg::REG_LUMA;
    cfg_if.data        = '0;
    luma_coeffs        = '0;
    chroma_a_coeffs    = '0;
    chroma_b_coeffs    = '0;
    slot_fill          = 0;
    word_accum         = '0;
    odd_pixel          = 1'b0;
    src_max_gap        = MAX_GAP;
    sink_max_gap       = MAX_GAP;
    hold_request       = 1'b0;
    mismatches         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines under BT.709 with full idling on both sides.
    load_matrix(coeff_word(Y_R, Y_G, Y_B, 1'b0), coeff_word(CB_R, CB_G, CB_B, 1'b0),
                coeff_word(CR_R, CR_G, CR_B, 1'b0));
    // single even pixel: line ends exactly on a word boundary
    pixel_backlog.push_back(make_pixel('0, '0, '0, 1'b1));
    // two pixels: odd end of line flushes a one-slot word
    pixel_backlog.push_back(make_pixel('1, '1, '1, 1'b0));
    pixel_backlog.push_back(make_pixel('1, '1, '1, 1'b1));
    // three pixels: last one completes a word and leaves a partial one
    pixel_backlog.push_back(make_pixel(16'hFFC0, 16'h0000, 16'h0000, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h0000, 16'hFFC0, 16'h0000, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h0000, 16'h0000, 16'hFFC0, 1'b1));
    // six pixels: odd pixel closes the line on a word boundary; low bits ignored
    pixel_backlog.push_back(make_pixel(16'h003F, 16'h003F, 16'h003F, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h0040, 16'h8000, 16'h7FFF, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
    // four pixels: odd end of line with two slots filled
    pixel_backlog.push_back(make_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h1234, 16'hFEDC, 16'h8001, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h7FC0, 16'h003F, 16'hFFC0, 1'b1));
    // five pixels: even end of line emits a full word then the partial one
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
    pixel_backlog.push_back(make_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0));
    pixel_backlog.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    wait_idle();

    // All-zero matrix: outputs are the bare offsets; no idling at all.
    src_max_gap  = 0;
    sink_max_gap = 0;
    load_matrix('0, '0, '0);
    queue_lines(150, 40);
    wait_idle();

    // All ones, bit 63 set too: every weight is -1, sums fall just below the offsets.
    src_max_gap  = MAX_GAP;
    sink_max_gap = MAX_GAP;
    load_matrix('1, '1, '1);
    queue_lines(150, 40);
    wait_idle();

    // Largest positive and most negative weights: sums run past 2^30 or below zero.
    src_max_gap  = 0;
    sink_max_gap = MAX_GAP;
    load_matrix(coeff_word(32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 1'b0),
                coeff_word(32'h100000, 32'h100000, 32'h100000, 1'b1),
                coeff_word(32'hFFFFF, 32'h100000, 32'hFFFFF, 1'b0));
    queue_lines(150, 40);
    wait_idle();

    // Random matrix; output held off for a long stretch while the sender
    // streams pixels back to back.
    src_max_gap  = 0;
    sink_max_gap = 3;
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    queue_lines(250, 64);
    hold_request = 1'b1;
    wait_idle();

    // BT.709 with chroma order swapped; sender pauses for a full drain midway.
    src_max_gap  = MAX_GAP;
    sink_max_gap = 0;
    load_matrix(coeff_word(Y_R, Y_G, Y_B, 1'b1), coeff_word(CR_R, CR_G, CR_B, 1'b0),
                coeff_word(CB_R, CB_G, CB_B, 1'b1));
    queue_lines(200, 40);
    wait_idle();
    sink_max_gap = MAX_GAP;
    queue_lines(200, 40);
    wait_idle();

    // Random matrix again, mixed idling.
    src_max_gap  = 5;
    sink_max_gap = 5;
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    queue_lines(228, 40);
    wait_idle();

    if (mismatches == 0)
      $display("[rgb_to_ycbcr_v210_packer] OK");
    else
      $display("[rgb_to_ycbcr_v210_packer] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("[rgb_to_ycbcr_v210_packer] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rgbv_pkg.sv
hdl/rgbv_pixel_if.sv
hdl/rgbv_word_if.sv
hdl/rgbv_cfg_if.sv
hdl/rgbv_front.sv
hdl/rgbv_queue.sv
hdl/rgbv_back.sv
hdl/rgb_to_ycbcr_v210_packer.sv
sim/rgb_to_ycbcr_v210_packer_tb.sv
